>>> sv/ppsd_pkg.sv
// Shared types and constants of the point-to-polygon signed distance block.
package ppsd_pkg;

  localparam int IN_FIELD_W = 32;
  localparam int IN_DATA_W  = 6 * IN_FIELD_W;
  localparam int DSQ_W      = 64;
  localparam int SQ_W       = DSQ_W + 2;
  localparam int ROOT_W     = DSQ_W / 2;
  localparam int SD_W       = ROOT_W + 1;
  localparam int OUT_DATA_W = 40;
  localparam int OUT_USER_W = 2;

  // One measured edge handed from the front to the accumulator.
  typedef struct packed {
    logic [DSQ_W-1:0] dsq;
    logic             dsat;
    logic             toggle;
    logic             first;
    logic             last;
  } ppsd_item_t;

endpackage

>>> sv/ppsd_front.sv
// Edge front end: crossing test, projection divide and squared distance per edge.
module ppsd_front import ppsd_pkg::*; #(
  parameter int COORD_BITS  = 32,
  parameter int T_FRAC_BITS = 32
) (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 in_valid,
  output logic                 in_ready,
  input  logic [IN_DATA_W-1:0] in_data,
  input  logic                 in_first,
  input  logic                 in_last,
  output logic                 push_valid,
  input  logic                 push_ready,
  output ppsd_item_t           push_item
);

  localparam int CW    = COORD_BITS + 1;
  localparam int MW    = (CW > T_FRAC_BITS + 1) ? CW : T_FRAC_BITS + 1;
  localparam int PW    = 2 * MW;
  localparam int NW    = PW + 1;
  localparam int RW    = NW + 1;
  localparam int CNT_W = $clog2(T_FRAC_BITS + 1);

  localparam logic [3:0] ST_RX_DD  = 4'd0;
  localparam logic [3:0] ST_DX_M   = 4'd1;
  localparam logic [3:0] ST_NUM_X  = 4'd2;
  localparam logic [3:0] ST_NUM_Y  = 4'd3;
  localparam logic [3:0] ST_DEN_X  = 4'd4;
  localparam logic [3:0] ST_DEN_Y  = 4'd5;
  localparam logic [3:0] ST_DECIDE = 4'd6;
  localparam logic [3:0] ST_TX     = 4'd7;
  localparam logic [3:0] ST_TY     = 4'd8;
  localparam logic [3:0] ST_EY     = 4'd9;
  localparam logic [3:0] ST_SQ_X   = 4'd10;
  localparam logic [3:0] ST_SQ_Y   = 4'd11;

  typedef enum logic [3:0] {
    F_IDLE = 4'b0001,
    F_MUL  = 4'b0010,
    F_DIV  = 4'b0100,
    F_PUSH = 4'b1000
  } fstate_t;

  fstate_t state_r;
  logic [3:0] step_r;

  logic signed [COORD_BITS-1:0] px, py, ax, ay, bx, by;
  logic signed [CW-1:0] dx_c, dy_c, rx_c, ry_c;

  logic signed [CW-1:0] dx_r, dy_r, rx_r, ry_r, pbx_r, pby_r, dd_r, m_r, ex_r, ey_r;
  logic                 cand_r, tog_r, first_r, last_r;
  logic signed [PW-1:0] pa_r, pb_r;
  logic signed [NW-1:0] num_r, den_r;
  logic [RW-1:0]        rem_r;
  logic [T_FRAC_BITS-1:0] t_r;
  logic [CNT_W-1:0]     cnt_r;
  logic [SQ_W-1:0]      sq_r;

  logic signed [MW-1:0] op_a, op_b, t_op;
  logic signed [PW-1:0] prod;
  logic [RW-1:0]        rem_sh, den_u;

  assign px = in_data[0*IN_FIELD_W +: COORD_BITS];
  assign py = in_data[1*IN_FIELD_W +: COORD_BITS];
  assign ax = in_data[2*IN_FIELD_W +: COORD_BITS];
  assign ay = in_data[3*IN_FIELD_W +: COORD_BITS];
  assign bx = in_data[4*IN_FIELD_W +: COORD_BITS];
  assign by = in_data[5*IN_FIELD_W +: COORD_BITS];

  assign dx_c = CW'(bx) - CW'(ax);
  assign dy_c = CW'(by) - CW'(ay);
  assign rx_c = CW'(px) - CW'(ax);
  assign ry_c = CW'(py) - CW'(ay);

  assign t_op = MW'($signed({1'b0, t_r}));

  // Shared multiplier: operands picked by the sequencer step.
  always_comb begin
    case (step_r)
      ST_RX_DD: begin op_a = MW'(rx_r); op_b = MW'(dd_r); end
      ST_DX_M:  begin op_a = MW'(dx_r); op_b = MW'(m_r);  end
      ST_NUM_X: begin op_a = MW'(rx_r); op_b = MW'(dx_r); end
      ST_NUM_Y: begin op_a = MW'(ry_r); op_b = MW'(dy_r); end
      ST_DEN_X: begin op_a = MW'(dx_r); op_b = MW'(dx_r); end
      ST_DEN_Y: begin op_a = MW'(dy_r); op_b = MW'(dy_r); end
      ST_TX:    begin op_a = MW'(dx_r); op_b = t_op;      end
      ST_TY:    begin op_a = MW'(dy_r); op_b = t_op;      end
      ST_SQ_X:  begin op_a = MW'(ex_r); op_b = MW'(ex_r); end
      ST_SQ_Y:  begin op_a = MW'(ey_r); op_b = MW'(ey_r); end
      default:  begin op_a = '0;        op_b = '0;        end
    endcase
  end

  assign prod   = op_a * op_b;
  assign rem_sh = {rem_r[RW-2:0], 1'b0};
  assign den_u  = RW'($unsigned(den_r));

  assign in_ready   = (state_r == F_IDLE);
  assign push_valid = (state_r == F_PUSH);

  always_comb begin
    push_item.dsat   = |sq_r[SQ_W-1:DSQ_W];
    push_item.dsq    = push_item.dsat ? '1 : sq_r[DSQ_W-1:0];
    push_item.toggle = tog_r;
    push_item.first  = first_r;
    push_item.last   = last_r;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= F_IDLE;
      step_r  <= ST_RX_DD;
    end else begin
      case (state_r)
        F_IDLE: begin
          if (in_valid) begin
            dx_r    <= dx_c;
            dy_r    <= dy_c;
            rx_r    <= rx_c;
            ry_r    <= ry_c;
            pbx_r   <= CW'(px) - CW'(bx);
            pby_r   <= CW'(py) - CW'(by);
            dd_r    <= dy_c[CW-1] ? -dy_c : dy_c;
            m_r     <= dy_c[CW-1] ? -ry_c : ry_c;
            cand_r  <= (ay > py) != (by > py);
            first_r <= in_first;
            last_r  <= in_last;
            step_r  <= ST_RX_DD;
            state_r <= F_MUL;
          end
        end
        F_MUL: begin
          case (step_r)
            ST_RX_DD: begin pa_r <= prod; step_r <= ST_DX_M; end
            ST_DX_M:  begin pb_r <= prod; step_r <= ST_NUM_X; end
            ST_NUM_X: begin num_r <= NW'(prod); step_r <= ST_NUM_Y; end
            ST_NUM_Y: begin
              num_r  <= num_r + NW'(prod);
              tog_r  <= cand_r && (pa_r < pb_r);
              step_r <= ST_DEN_X;
            end
            ST_DEN_X: begin den_r <= NW'(prod); step_r <= ST_DEN_Y; end
            ST_DEN_Y: begin den_r <= den_r + NW'(prod); step_r <= ST_DECIDE; end
            ST_DECIDE: begin
              if (den_r == 0 || num_r <= 0) begin
                ex_r   <= rx_r;
                ey_r   <= ry_r;
                step_r <= ST_SQ_X;
              end else if (num_r >= den_r) begin
                ex_r   <= pbx_r;
                ey_r   <= pby_r;
                step_r <= ST_SQ_X;
              end else begin
                rem_r   <= RW'($unsigned(num_r));
                t_r     <= '0;
                cnt_r   <= '0;
                state_r <= F_DIV;
              end
            end
            ST_TX: begin pa_r <= prod; step_r <= ST_TY; end
            ST_TY: begin
              ex_r   <= rx_r - CW'(pa_r >>> T_FRAC_BITS);
              pb_r   <= prod;
              step_r <= ST_EY;
            end
            ST_EY: begin
              ey_r   <= ry_r - CW'(pb_r >>> T_FRAC_BITS);
              step_r <= ST_SQ_X;
            end
            ST_SQ_X: begin sq_r <= SQ_W'(prod); step_r <= ST_SQ_Y; end
            ST_SQ_Y: begin
              sq_r    <= sq_r + SQ_W'(prod);
              state_r <= F_PUSH;
            end
            default: step_r <= ST_RX_DD;
          endcase
        end
        F_DIV: begin
          // Restoring divide, one quotient bit a cycle.
          if (rem_sh >= den_u) begin
            rem_r <= rem_sh - den_u;
            t_r   <= {t_r[T_FRAC_BITS-2:0], 1'b1};
          end else begin
            rem_r <= rem_sh;
            t_r   <= {t_r[T_FRAC_BITS-2:0], 1'b0};
          end
          cnt_r <= cnt_r + 1'b1;
          if (cnt_r == CNT_W'(T_FRAC_BITS - 1)) begin
            step_r  <= ST_TX;
            state_r <= F_MUL;
          end
        end
        F_PUSH: begin
          if (push_ready) state_r <= F_IDLE;
        end
        default: state_r <= F_IDLE;
      endcase
    end
  end

endmodule

>>> sv/ppsd_queue.sv
// Two-entry queue between the edge front end and the accumulator.
module ppsd_queue import ppsd_pkg::*; (
  input  logic       clk,
  input  logic       rst_n,
  input  logic       wr_valid,
  output logic       wr_ready,
  input  ppsd_item_t wr_item,
  output logic       rd_valid,
  input  logic       rd_ready,
  output ppsd_item_t rd_item
);

  ppsd_item_t mem_r [2];
  logic       wptr_r, rptr_r;
  logic [1:0] cnt_r;
  logic       do_wr, do_rd;

  assign wr_ready = (cnt_r != 2'd2);
  assign rd_valid = (cnt_r != 2'd0);
  assign rd_item  = mem_r[rptr_r];
  assign do_wr    = wr_valid && wr_ready;
  assign do_rd    = rd_valid && rd_ready;

  always_ff @(posedge clk) begin
    if (do_wr) mem_r[wptr_r] <= wr_item;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wptr_r <= 1'b0;
      rptr_r <= 1'b0;
      cnt_r  <= 2'd0;
    end else begin
      if (do_wr) wptr_r <= ~wptr_r;
      if (do_rd) rptr_r <= ~rptr_r;
      case ({do_wr, do_rd})
        2'b10:   cnt_r <= cnt_r + 2'd1;
        2'b01:   cnt_r <= cnt_r - 2'd1;
        default: cnt_r <= cnt_r;
      endcase
    end
  end

endmodule

>>> sv/ppsd_back.sv
// Accumulator: parity and running minimum, square root and result register.
module ppsd_back import ppsd_pkg::*; (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  q_valid,
  output logic                  q_ready,
  input  ppsd_item_t            q_item,
  output logic                  out_tvalid,
  input  logic                  out_tready,
  output logic [OUT_DATA_W-1:0] out_tdata,
  output logic [OUT_USER_W-1:0] out_tuser
);

  typedef enum logic [2:0] {
    B_ACC  = 3'b001,
    B_ROOT = 3'b010,
    B_HOLD = 3'b100
  } bstate_t;

  bstate_t bstate_r;
  logic [DSQ_W-1:0] min_r, base_min, new_min;
  logic             par_r, sat_r, base_par, base_sat, new_par, new_sat;
  logic [DSQ_W-1:0] rv_r, res_r, rbit_r, trial;
  logic             rpar_r, rsat_r;
  logic             out_valid_r;
  logic [SD_W-1:0]  sd_r, mag;
  logic             in_r, sf_r;
  logic             load_out;

  assign q_ready = (bstate_r == B_ACC);

  always_comb begin
    base_min = q_item.first ? '1 : min_r;
    base_par = q_item.first ? 1'b0 : par_r;
    base_sat = q_item.first ? 1'b0 : sat_r;
    new_par  = base_par ^ q_item.toggle;
    new_min  = base_min;
    new_sat  = base_sat;
    if (q_item.dsq < base_min) begin
      new_min = q_item.dsq;
      new_sat = q_item.dsat;
    end else if (q_item.dsq == base_min) begin
      new_sat = base_sat | q_item.dsat;
    end
  end

  assign trial    = res_r + rbit_r;
  assign load_out = (bstate_r == B_HOLD) && (!out_valid_r || out_tready);
  assign mag      = {1'b0, res_r[ROOT_W-1:0]};

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      bstate_r    <= B_ACC;
      min_r       <= '1;
      par_r       <= 1'b0;
      sat_r       <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      if (load_out) out_valid_r <= 1'b1;
      else if (out_tready) out_valid_r <= 1'b0;
      case (bstate_r)
        B_ACC: begin
          if (q_valid) begin
            min_r <= new_min;
            par_r <= new_par;
            sat_r <= new_sat;
            if (q_item.last) begin
              rv_r     <= new_min;
              res_r    <= '0;
              rbit_r   <= DSQ_W'(1) << (DSQ_W - 2);
              rpar_r   <= new_par;
              rsat_r   <= new_sat;
              bstate_r <= B_ROOT;
            end
          end
        end
        B_ROOT: begin
          // One root bit per cycle.
          if (rv_r >= trial) begin
            rv_r  <= rv_r - trial;
            res_r <= (res_r >> 1) + rbit_r;
          end else begin
            res_r <= res_r >> 1;
          end
          rbit_r <= rbit_r >> 2;
          if (rbit_r[0]) bstate_r <= B_HOLD;
        end
        B_HOLD: begin
          if (load_out) begin
            sd_r     <= rpar_r ? mag : -mag;
            in_r     <= rpar_r;
            sf_r     <= rsat_r;
            bstate_r <= B_ACC;
          end
        end
        default: bstate_r <= B_ACC;
      endcase
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = OUT_DATA_W'(sd_r);
  assign out_tuser  = {sf_r, in_r};

endmodule

>>> sv/point_polygon_signed_distance_core.sv
// Top level of the point-to-polygon signed distance block.
//
// Usage: stream every edge of every ring of a polygon, closing edges included,
// one beat per edge on the in_ channel. Each beat carries the query point, the
// current vertex and the preceding vertex. Raise in_tuser (first edge) on the
// opening beat of a query to clear parity and minimum; raise in_tlast on the
// final beat. One result beat follows each in_tlast beat on the out_ channel.
// The front end takes a new beat only once it has pushed the previous edge,
// stepping through a shared 33x33 multiplier and, when the projection is
// divided, a one-bit-per-cycle divider. The accumulator folds each queued
// edge as it is taken; after the last edge a bit-serial square root and a
// load into the output register produce the result.
// Reset clears the handshakes, the queue, parity (outside) and the minimum
// (all ones). A stalled out_ beat holds in its output register while the front
// end keeps taking edges; the two-entry queue and the accumulator back up only
// when another result is ready behind it.
module point_polygon_signed_distance_core import ppsd_pkg::*; #(
  parameter int COORD_BITS  = 32,
  parameter int T_FRAC_BITS = 32
) (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  in_tvalid,
  output logic                  in_tready,
  // point_lon, point_lat, edge_start_lon, edge_start_lat, edge_end_lon, edge_end_lat
  input  logic [IN_DATA_W-1:0]  in_tdata,
  // first_edge
  input  logic                  in_tuser,
  input  logic                  in_tlast,
  output logic                  out_tvalid,
  input  logic                  out_tready,
  // signed_distance [32:0], zero fill
  output logic [OUT_DATA_W-1:0] out_tdata,
  // is_inside, saturated
  output logic [OUT_USER_W-1:0] out_tuser
);

  logic       f_valid, f_ready, b_valid, b_ready;
  ppsd_item_t f_item, b_item;

  ppsd_front #(
    .COORD_BITS  (COORD_BITS),
    .T_FRAC_BITS (T_FRAC_BITS)
  ) u_front (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_valid   (in_tvalid),
    .in_ready   (in_tready),
    .in_data    (in_tdata),
    .in_first   (in_tuser),
    .in_last    (in_tlast),
    .push_valid (f_valid),
    .push_ready (f_ready),
    .push_item  (f_item)
  );

  ppsd_queue u_queue (
    .clk      (clk),
    .rst_n    (rst_n),
    .wr_valid (f_valid),
    .wr_ready (f_ready),
    .wr_item  (f_item),
    .rd_valid (b_valid),
    .rd_ready (b_ready),
    .rd_item  (b_item)
  );

  ppsd_back u_back (
    .clk        (clk),
    .rst_n      (rst_n),
    .q_valid    (b_valid),
    .q_ready    (b_ready),
    .q_item     (b_item),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tuser  (out_tuser)
  );

endmodule

>>> sv/ppsd_checker.sv
// Port checker for the signed distance block and its bind.
module ppsd_checker import ppsd_pkg::*; (
  input logic                  clk,
  input logic                  rst_n,
  input logic                  out_tvalid,
  input logic                  out_tready,
  input logic [OUT_DATA_W-1:0] out_tdata,
  input logic [OUT_USER_W-1:0] out_tuser
);

  a_hold_valid: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tready |=> out_tvalid)
    else $error("result beat dropped while stalled");

  a_hold_data: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tready |=> $stable(out_tdata) && $stable(out_tuser))
    else $error("result payload changed while stalled");

  a_sign: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid |-> (out_tuser[0] && !out_tdata[32]) ||
                   (!out_tuser[0] && (out_tdata[32] || out_tdata[32:0] == 33'd0)))
    else $error("distance sign disagrees with inside flag");

  a_sat: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && out_tuser[1] |->
      (out_tuser[0] && out_tdata[32:0] == 33'h0FFFFFFFF) ||
      (!out_tuser[0] && out_tdata[32:0] == 33'h100000001))
    else $error("saturated result is not the largest distance");

  a_reset: assert property (@(posedge clk) !rst_n |=> !out_tvalid)
    else $error("result valid right after reset");

endmodule

bind point_polygon_signed_distance_core ppsd_checker u_ppsd_checker (.*);

>>> tb/sv/tb_point_polygon_signed_distance_core.sv
// Self-checking testbench of the point-to-polygon signed distance core.
`timescale 1ns / 1ps

module tb_point_polygon_signed_distance_core;
  import ppsd_pkg::*;

  localparam int WATCHDOG_LIMIT = 20000;
  localparam int DRAIN_CYCLES   = 120;
  localparam int PHASE_ITEMS    = 300;
  localparam int T_FRAC_BITS_TB = 32;

  typedef struct {
    logic [IN_DATA_W-1:0] data;
    logic                 first;
    logic                 last;
  } edge_beat_t;

  typedef struct {
    logic [SD_W-1:0] sdist;
    logic            in_poly;
    logic            sat;
  } dist_result_t;

  logic                  clk;
  logic                  rst_n;
  logic                  in_tvalid;
  logic                  in_tready;
  logic [IN_DATA_W-1:0]  in_tdata;
  logic                  in_tuser;
  logic                  in_tlast;
  logic                  out_tvalid;
  logic                  out_tready;
  logic [OUT_DATA_W-1:0] out_tdata;
  logic [OUT_USER_W-1:0] out_tuser;

  edge_beat_t   edge_q[$];
  dist_result_t result_q[$];

  int  send_idle_pct;
  int  recv_idle_pct;
  int  rx_hold_cnt;
  logic rx_hold_req;
  int  mismatch_cnt;
  int  quiet_cycles;
  bit  sim_done;

  // Predictor state: ray-cast parity, kept minimum and its saturation flag.
  logic        pred_parity;
  logic [63:0] pred_min_dsq;
  logic        pred_sat;

  point_polygon_signed_distance_core u_top (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .in_tuser   (in_tuser),
    .in_tlast   (in_tlast),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tuser  (out_tuser)
  );

  initial begin
    clk = 1'b0;
    forever #6 clk = ~clk;
  end

  // Floor square root, one result bit per pass.
  function automatic logic [63:0] floor_sqrt(input logic [63:0] v);
    logic [63:0] res;
    logic [63:0] bitv;
    res  = '0;
    bitv = 64'd1 << 62;
    while (bitv > v) bitv = bitv >> 2;
    while (bitv != 0) begin
      if (v >= res + bitv) begin
        v   = v - (res + bitv);
        res = (res >> 1) + bitv;
      end else begin
        res = res >> 1;
      end
      bitv = bitv >> 2;
    end
    return res;
  endfunction

  // Fold one accepted edge into the predicted state; queue a result on last.
  task automatic fold_edge(input logic [IN_DATA_W-1:0] d, input logic first,
                           input logic last);
    logic signed [127:0] px, py, ax, ay, bx, by, dx, dy, rx, ry, ex, ey;
    logic signed [127:0] dd, mm, num, den, tq, sq;
    logic [63:0] dsq, root;
    logic        dsat;
    dist_result_t r;
    px = $signed(d[31:0]);    py = $signed(d[63:32]);
    ax = $signed(d[95:64]);   ay = $signed(d[127:96]);
    bx = $signed(d[159:128]); by = $signed(d[191:160]);
    dx = bx - ax; dy = by - ay;
    rx = px - ax; ry = py - ay;
    ex = rx; ey = ry;
    if (first) begin
      pred_parity  = 1'b0;
      pred_min_dsq = '1;
      pred_sat     = 1'b0;
    end
    // Crossing test by cross-multiplication, divisor made positive.
    if ((ay > py) != (by > py)) begin
      dd = (dy < 0) ? -dy : dy;
      mm = (dy < 0) ? -ry : ry;
      if (rx * dd < dx * mm) pred_parity = ~pred_parity;
    end
    if (dx != 0 || dy != 0) begin
      num = rx * dx + ry * dy;
      den = dx * dx + dy * dy;
      if (num > 0) begin
        if (num >= den) begin
          ex = px - bx;
          ey = py - by;
        end else begin
          tq = (num <<< T_FRAC_BITS_TB) / den;
          ex = rx - ((dx * tq) >>> T_FRAC_BITS_TB);
          ey = ry - ((dy * tq) >>> T_FRAC_BITS_TB);
        end
      end
    end
    sq   = ex * ex + ey * ey;
    dsat = (sq[127:64] != 0);
    dsq  = dsat ? '1 : sq[63:0];
    if (dsq < pred_min_dsq) begin
      pred_min_dsq = dsq;
      pred_sat     = dsat;
    end else if (dsq == pred_min_dsq) begin
      pred_sat = pred_sat | dsat;
    end
    if (last) begin
      root      = floor_sqrt(pred_min_dsq);
      r.sdist   = pred_parity ? root[SD_W-1:0] : (SD_W)'(0) - root[SD_W-1:0];
      r.in_poly = pred_parity;
      r.sat     = pred_sat;
      result_q.insert(result_q.size(), r);
    end
  endtask

  // Driver: present the next queued edge when the slot is free, with random idle gaps.
  always @(posedge clk) begin
    edge_beat_t b;
    if (!rst_n) begin
      in_tvalid <= 1'b0;
    end else if (!in_tvalid || in_tready) begin
      if (edge_q.size() > 0 && $urandom_range(99) >= send_idle_pct) begin
        b = edge_q.pop_front();
        in_tdata  <= b.data;
        in_tuser  <= b.first;
        in_tlast  <= b.last;
        in_tvalid <= 1'b1;
      end else begin
        in_tvalid <= 1'b0;
      end
    end
  end

  // Receiver: random back-pressure, plus a long hold-off on request.
  always @(posedge clk) begin
    if (!rst_n) begin
      out_tready  <= 1'b0;
      rx_hold_cnt <= 0;
    end else if (rx_hold_req && rx_hold_cnt == 0) begin
      rx_hold_cnt <= 400;
      out_tready  <= 1'b0;
      rx_hold_req <= 1'b0;
    end else if (rx_hold_cnt > 0) begin
      rx_hold_cnt <= rx_hold_cnt - 1;
      out_tready  <= 1'b0;
    end else begin
      out_tready <= ($urandom_range(99) >= recv_idle_pct);
    end
  end

  // Monitor: predict on input beats, check on output beats, watch for hangs.
  always @(posedge clk) begin
    dist_result_t e;
    if (rst_n) begin
      if (in_tvalid && in_tready) fold_edge(in_tdata, in_tuser, in_tlast);
      if (out_tvalid && out_tready) begin
        if (result_q.size() == 0) begin
          mismatch_cnt++;
          if (mismatch_cnt <= 10)
            $display("unexpected result beat: sd=%h user=%b", out_tdata, out_tuser);
        end else begin
          e = result_q.pop_front();
          if (out_tdata[SD_W-1:0] !== e.sdist || out_tdata[OUT_DATA_W-1:SD_W] !== '0 ||
              out_tuser[0] !== e.in_poly || out_tuser[1] !== e.sat) begin
            mismatch_cnt++;
            if (mismatch_cnt <= 10)
              $display("mismatch: sd exp %h got %h, inside exp %b got %b, sat exp %b got %b",
                       e.sdist, out_tdata, e.in_poly, out_tuser[0], e.sat, out_tuser[1]);
          end
        end
      end
      if ((in_tvalid && in_tready) || (out_tvalid && out_tready) || sim_done)
        quiet_cycles <= 0;
      else if (quiet_cycles + 1 >= WATCHDOG_LIMIT) begin
        $display("tb_point_polygon_signed_distance_core: FAIL");
        $finish;
      end else
        quiet_cycles <= quiet_cycles + 1;
    end
  end

  function automatic logic [31:0] pick_coord(input int mode);
    case (mode)
      0:       return 32'($signed($urandom_range(2000)) - 1000);
      1:       return 32'($signed($urandom_range(36000)) - 18000) * 32'd100000
                      + 32'($urandom_range(99999));
      default: return $urandom;
    endcase
  endfunction

  task automatic push_edge(input logic [31:0] plon, plat, alon, alat, blon, blat,
                           input logic first, input logic last);
    edge_beat_t b;
    b.data  = {blat, blon, alat, alon, plat, plon};
    b.first = first;
    b.last  = last;
    edge_q.insert(edge_q.size(), b);
  endtask

  // Queue one query: point plus one or two closed rings, mostly centred on it.
  task automatic push_query(input int mode, input bit with_first, input bit with_last,
                            inout int count);
    logic [31:0] plon, plat, clon, clat;
    logic [31:0] vlon[6], vlat[6];
    int rings, n, spread;
    plon   = pick_coord(mode);
    plat   = pick_coord(mode);
    rings  = ($urandom_range(9) == 0) ? 2 : 1;
    spread = (mode == 0) ? 20 : 2000;
    for (int r = 0; r < rings; r++) begin
      n = $urandom_range(3, 6);
      clon = ($urandom_range(3) == 0) ? pick_coord(mode) : plon;
      clat = ($urandom_range(3) == 0) ? pick_coord(mode) : plat;
      for (int i = 0; i < n; i++) begin
        vlon[i] = clon + 32'($signed($urandom_range(2 * spread)) - spread);
        vlat[i] = clat + 32'($signed($urandom_range(2 * spread)) - spread);
        // repeat a vertex now and then to get zero-length edges
        if (i > 0 && $urandom_range(11) == 0) begin
          vlon[i] = vlon[i-1];
          vlat[i] = vlat[i-1];
        end
      end
      for (int i = 0; i < n; i++) begin
        push_edge(plon, plat, vlon[i], vlat[i], vlon[(i+n-1)%n], vlat[(i+n-1)%n],
                  with_first && r == 0 && i == 0,
                  with_last && r == rings - 1 && i == n - 1);
        count++;
      end
    end
  endtask

  task automatic wait_idle();
    wait (edge_q.size() == 0 && result_q.size() == 0 && !in_tvalid);
    repeat (DRAIN_CYCLES) @(posedge clk);
  endtask

  task automatic run_phase(input int s_pct, input int r_pct, input bit do_hold);
    int cnt;
    int sel;
    cnt = 0;
    send_idle_pct = s_pct;
    recv_idle_pct = r_pct;
    while (cnt < PHASE_ITEMS) begin
      sel = $urandom_range(99);
      if (sel < 55)      push_query(0, 1'b1, 1'b1, cnt);
      else if (sel < 75) push_query(1, 1'b1, 1'b1, cnt);
      else if (sel < 85) push_query(2, 1'b1, 1'b1, cnt);
      else if (sel < 90) push_query(0, 1'b0, 1'b1, cnt);
      else begin
        // noise: lone edges with random flags and raw coordinates
        push_edge($urandom, $urandom, $urandom, $urandom, $urandom, $urandom,
                  $urandom_range(1), $urandom_range(3) == 0);
        cnt++;
      end
      if (do_hold && cnt > PHASE_ITEMS / 2) begin
        @(posedge clk);
        rx_hold_req <= 1'b1;
        do_hold = 1'b0;
      end
    end
    // pause the sender until every result of this phase is back
    wait_idle();
  endtask

  initial begin
    int dummy;
    rst_n         = 1'b0;
    in_tvalid     = 1'b0;
    in_tdata      = '0;
    in_tuser      = 1'b0;
    in_tlast      = 1'b0;
    out_tready    = 1'b0;
    rx_hold_req   = 1'b0;
    send_idle_pct = 0;
    recv_idle_pct = 0;
    mismatch_cnt  = 0;
    quiet_cycles  = 0;
    sim_done      = 1'b0;
    pred_parity   = 1'b0;
    pred_min_dsq  = '1;
    pred_sat      = 1'b0;
    repeat (4) @(posedge clk);
    rst_n <= 1'b1;

    // Directed: zero-length edge on the point, outside zero distance.
    push_edge(0, 0, 0, 0, 0, 0, 1'b1, 1'b1);
    // Saturating squared distance across the coordinate range.
    push_edge(-1800000000, -1800000000, 1800000000, 1800000000,
              1800000000, 1800000000, 1'b1, 1'b1);
    // Raw extremes of the 32-bit fields.
    push_edge(32'h8000_0000, 32'h8000_0000, 32'h7fff_ffff, 32'h7fff_ffff,
              32'h8000_0000, 32'h7fff_ffff, 1'b1, 1'b1);
    push_edge(32'hffff_ffff, 32'h0000_0000, 32'h7fff_ffff, 32'h8000_0000,
              32'h8000_0000, 32'h7fff_ffff, 1'b1, 1'b1);
    // Square ring around the point: inside, projection onto edges.
    push_edge(5, 5, 10, 0, 0, 0, 1'b1, 1'b0);
    push_edge(5, 5, 10, 10, 10, 0, 1'b0, 1'b0);
    push_edge(5, 5, 0, 10, 10, 10, 1'b0, 1'b0);
    push_edge(5, 5, 0, 0, 0, 10, 1'b0, 1'b1);
    // Same point continues without a first edge: accumulation carries on.
    push_edge(5, 5, 6, 5, 6, 5, 1'b0, 1'b1);
    // Point past the far endpoint, then before the near one.
    push_edge(20, 3, 0, 0, 10, 0, 1'b1, 1'b0);
    push_edge(-7, -2, 0, 0, 10, 0, 1'b0, 1'b1);
    // Point on a vertex of an outside ring and exactly on the ray level.
    push_edge(3, 0, 3, 0, 8, 4, 1'b1, 1'b0);
    push_edge(3, 0, 8, -4, 3, 0, 1'b0, 1'b1);
    // Two equal saturated distances keep the flag.
    push_edge(-1800000000, 1800000000, 1800000000, -1800000000,
              1800000000, -1800000000, 1'b1, 1'b0);
    push_edge(-1800000000, 1800000000, 1800000000, -1800000000,
              1800000000, -1800000000, 1'b0, 1'b1);
    wait_idle();

    run_phase(11, 58, 1'b1);
    run_phase(58, 11, 1'b0);
    run_phase(0, 0, 1'b1);

    sim_done = 1'b1;
    if (mismatch_cnt == 0)
      $display("tb_point_polygon_signed_distance_core: PASS");
    else
      $display("tb_point_polygon_signed_distance_core: FAIL");
    $finish;
  end

endmodule
